FILE: rtl/salc_pkg.sv
// Shared types, codes and widths for the set-associative LRU cache.
package salc_pkg;

    localparam int KEY_W  = 31;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 32;
    localparam int SIU_W  = 7;
    localparam int STEP_W = 5;

    // Operation codes
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    localparam logic [SIU_W-1:0] SIU_RESET = 7'd64;

    typedef struct packed {
        logic                     func;
        logic [KEY_W-1:0]         key;
        logic signed [DATA_W-1:0] write_data;
    } salc_item_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]         hit_total;
        logic [CNT_W-1:0]         miss_total;
    } salc_result_t;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] dividend;
        logic [SIU_W-1:0] divisor;
    } salc_rem_req_t;

    typedef struct packed {
        logic             done;
        logic [SIU_W-1:0] remainder;
    } salc_rem_rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVIDE,
        ST_META,
        ST_SEARCH,
        ST_UPDATE
    } salc_state_t;

endpackage

FILE: rtl/set_assoc_lru_cache.sv
// Top level of the set-associative key/value cache with LRU replacement.
//
//  channel   ports                        handshake
//  --------  ---------------------------  ------------------------------------
//  item      item (func,key,write_data)   beat taken when start && !busy
//  result    result (hit,read_data,...)   one beat per item, done high 1 cycle
//  config    cfg_we, cfg_wdata            sets_in_use written when cfg_we
//
// Each item runs the 31-step bit-serial remainder and a set state read; a get
// then makes one way compare per cycle until a hit or the last way is checked.
// After reset a clearing pass sweeps every row of the set state memory;
// busy stays high during it. done is shown for exactly one cycle and
// the receiver cannot stall it; the next item may start as done is shown.
module set_assoc_lru_cache #(
    parameter int SETS = 64,
    parameter int WAYS = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  salc_pkg::salc_item_t               item,
    output logic                               done,
    output salc_pkg::salc_result_t             result,
    input  logic                               cfg_we,
    input  logic [salc_pkg::SIU_W-1:0]         cfg_wdata
);

    localparam int KW     = salc_pkg::KEY_W;
    localparam int DW     = salc_pkg::DATA_W;
    localparam int CW     = salc_pkg::CNT_W;
    localparam int SW     = salc_pkg::SIU_W;
    localparam int SIDX   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WIDX   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int EAW    = SIDX + WIDX;
    localparam int EDEPTH = SETS * (2 ** WIDX);
    localparam int MW     = WAYS + WAYS * WIDX;
    localparam int EW     = KW + DW;
    localparam logic [SW-1:0] SETS_CAP = (SETS > 127) ? 7'd127 : SW'(SETS);

    typedef logic [WAYS-1:0][WIDX-1:0] order_t;

    // Move one way to the front of a recency list
    function automatic order_t mru(input order_t ord, input logic [WIDX-1:0] way);
        order_t res;
        int     pos;
        logic   found;
        pos   = WAYS - 1;
        found = 1'b0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (!found && ord[i] == way)
            begin
                pos   = i;
                found = 1'b1;
            end
        end
        res[0] = way;
        for (int i = 1; i < WAYS; i++)
            res[i] = (i <= pos) ? ord[i-1] : ord[i];
        return res;
    endfunction

    salc_pkg::salc_state_t  state_reg, state_next;
    logic [SW-1:0]          cfg_reg;
    logic [SIDX-1:0]        clr_reg, clr_next;
    logic                   func_reg, func_next;
    logic [KW-1:0]          key_reg, key_next;
    logic [DW-1:0]          wdata_reg, wdata_next;
    logic [SIDX-1:0]        set_reg, set_next;
    logic [WIDX-1:0]        way_reg, way_next;
    logic [CW-1:0]          hit_cnt_reg, hit_cnt_next;
    logic [CW-1:0]          miss_cnt_reg, miss_cnt_next;
    logic                   done_reg, done_next;
    salc_pkg::salc_result_t result_reg, result_next;

    salc_pkg::salc_rem_req_t rem_req;
    salc_pkg::salc_rem_rsp_t rem_rsp;

    logic [SW-1:0]      eff_sets;
    logic [SW+SIDX-1:0] rem_wide;
    logic [SIDX-1:0]    rem_set;

    logic [MW-1:0]   meta_mem [SETS];
    logic [MW-1:0]   meta_q;
    logic            meta_rd, meta_we;
    logic [SIDX-1:0] meta_raddr, meta_waddr;
    logic [MW-1:0]   meta_wdata;
    logic [WAYS-1:0] meta_valid;
    order_t          meta_order;
    order_t          ident_order;

    logic [EW-1:0]   ent_mem [EDEPTH];
    logic [EW-1:0]   ent_q;
    logic            ent_rd, ent_we;
    logic [EAW-1:0]  ent_raddr, ent_waddr;
    logic [EW-1:0]   ent_wdata;

    logic [WIDX-1:0] put_way;
    logic [WAYS-1:0] way_bit;
    logic            way_hit;
    logic            last_way;

    salc_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    // Clamp the configured set count to 1..SETS, and to at most 127
    always_comb
    begin
        if (cfg_reg == '0)
            eff_sets = SW'(1);
        else if (cfg_reg > SETS_CAP)
            eff_sets = SETS_CAP;
        else
            eff_sets = cfg_reg;
    end

    assign rem_wide = {{SIDX{1'b0}}, rem_rsp.remainder};
    assign rem_set  = rem_wide[SIDX-1:0];

    // Unpack the set state row
    assign meta_valid = meta_q[MW-1 -: WAYS];
    assign meta_order = meta_q[WAYS*WIDX-1:0];

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
            ident_order[i] = WIDX'(i);
    end

    // Pick the first empty way, else the least recent one
    always_comb
    begin
        logic found;
        found   = 1'b0;
        put_way = meta_order[WAYS-1];
        for (int i = 0; i < WAYS; i++)
        begin
            if (!found && !meta_valid[i])
            begin
                put_way = WIDX'(i);
                found   = 1'b1;
            end
        end
    end

    assign way_bit  = WAYS'(1) << way_reg;
    assign way_hit  = meta_valid[way_reg] && (ent_q[EW-1 -: KW] == key_reg);
    assign last_way = (way_reg == WIDX'(WAYS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            salc_pkg::ST_CLEAR:
                if (clr_reg == SIDX'(SETS - 1))
                    state_next = salc_pkg::ST_IDLE;
            salc_pkg::ST_IDLE:
                if (start)
                    state_next = salc_pkg::ST_DIVIDE;
            salc_pkg::ST_DIVIDE:
                if (rem_rsp.done)
                    state_next = salc_pkg::ST_META;
            salc_pkg::ST_META:
                if (func_reg == salc_pkg::FUNC_PUT)
                    state_next = salc_pkg::ST_UPDATE;
                else
                    state_next = salc_pkg::ST_SEARCH;
            salc_pkg::ST_SEARCH:
                if (way_hit)
                    state_next = salc_pkg::ST_UPDATE;
                else if (last_way)
                    state_next = salc_pkg::ST_IDLE;
            salc_pkg::ST_UPDATE:
                state_next = salc_pkg::ST_IDLE;
            default:
                state_next = salc_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        clr_next      = clr_reg;
        func_next     = func_reg;
        key_next      = key_reg;
        wdata_next    = wdata_reg;
        set_next      = set_reg;
        way_next      = way_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        rem_req       = '{start: 1'b0, dividend: item.key, divisor: eff_sets};
        meta_rd       = 1'b0;
        meta_raddr    = rem_set;
        meta_we       = 1'b0;
        meta_waddr    = set_reg;
        meta_wdata    = {meta_valid | way_bit, mru(meta_order, way_reg)};
        ent_rd        = 1'b0;
        ent_raddr     = {set_reg, way_reg};
        ent_we        = 1'b0;
        ent_waddr     = {set_reg, way_reg};
        ent_wdata     = {key_reg, wdata_reg};
        case (state_reg)
            salc_pkg::ST_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                meta_wdata = {{WAYS{1'b0}}, ident_order};
                clr_next   = clr_reg + SIDX'(1);
            end
            salc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    func_next     = item.func;
                    key_next      = item.key;
                    wdata_next    = item.write_data;
                    rem_req.start = 1'b1;
                end
            end
            salc_pkg::ST_DIVIDE:
            begin
                if (rem_rsp.done)
                begin
                    set_next = rem_set;
                    meta_rd  = 1'b1;
                end
            end
            salc_pkg::ST_META:
            begin
                if (func_reg == salc_pkg::FUNC_PUT)
                    way_next = put_way;
                else
                begin
                    way_next  = '0;
                    ent_rd    = 1'b1;
                    ent_raddr = {set_reg, {WIDX{1'b0}}};
                end
            end
            salc_pkg::ST_SEARCH:
            begin
                if (!way_hit)
                begin
                    if (last_way)
                    begin
                        miss_cnt_next = miss_cnt_reg + CW'(1);
                        done_next     = 1'b1;
                        result_next   = '{hit: 1'b0, read_data: '0,
                                          hit_total: hit_cnt_reg,
                                          miss_total: miss_cnt_reg + CW'(1)};
                    end
                    else
                    begin
                        way_next  = way_reg + WIDX'(1);
                        ent_rd    = 1'b1;
                        ent_raddr = {set_reg, way_reg + WIDX'(1)};
                    end
                end
            end
            salc_pkg::ST_UPDATE:
            begin
                meta_we   = 1'b1;
                done_next = 1'b1;
                if (func_reg == salc_pkg::FUNC_PUT)
                begin
                    ent_we      = 1'b1;
                    result_next = '{hit: 1'b0, read_data: '0,
                                    hit_total: hit_cnt_reg,
                                    miss_total: miss_cnt_reg};
                end
                else
                begin
                    hit_cnt_next = hit_cnt_reg + CW'(1);
                    result_next  = '{hit: 1'b1, read_data: ent_q[DW-1:0],
                                     hit_total: hit_cnt_reg + CW'(1),
                                     miss_total: miss_cnt_reg};
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= salc_pkg::ST_CLEAR;
            cfg_reg      <= salc_pkg::SIU_RESET;
            clr_reg      <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            done_reg     <= done_next;
            if (cfg_we)
                cfg_reg <= cfg_wdata;
        end
    end

    // Hold the captured item and the result beat
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        key_reg    <= key_next;
        wdata_reg  <= wdata_next;
        set_reg    <= set_next;
        way_reg    <= way_next;
        result_reg <= result_next;
    end

    // Set state memory: valid bits and recency list per set
    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[meta_waddr] <= meta_wdata;
        if (meta_rd)
            meta_q <= meta_mem[meta_raddr];
    end

    // Key and value memory, one way per address
    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_waddr] <= ent_wdata;
        if (ent_rd)
            ent_q <= ent_mem[ent_raddr];
    end

    assign busy   = (state_reg != salc_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    // A result beat never repeats in the next cycle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    // An accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // A result is shown only once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == salc_pkg::ST_IDLE))
        else $error("result shown while sequencer active");

    // The remainder finishes only while the sequencer waits for it
    a_rem_divide: assert property (@(posedge clk) disable iff (!rst_n)
        rem_rsp.done |-> (state_reg == salc_pkg::ST_DIVIDE))
        else $error("remainder finished outside divide step");
`endif

endmodule

FILE: rtl/salc_rem.sv
// Bit-serial restoring remainder unit: key modulo a 7-bit set count.
module salc_rem (
    input  logic                    clk,
    input  logic                    rst_n,
    input  salc_pkg::salc_rem_req_t req,
    output salc_pkg::salc_rem_rsp_t rsp
);

    localparam int KW = salc_pkg::KEY_W;
    localparam int SW = salc_pkg::SIU_W;
    localparam int TW = salc_pkg::STEP_W;

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [TW-1:0] step_reg, step_next;
    logic [KW-1:0] shift_reg, shift_next;
    logic [SW-1:0] div_reg, div_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [SW:0]   trial;

    // Shift in one dividend bit per cycle and subtract when it fits
    always_comb
    begin
        trial      = {rem_reg, shift_reg[KW-1]};
        run_next   = run_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        if (req.start)
        begin
            run_next   = 1'b1;
            step_next  = '0;
            shift_next = req.dividend;
            div_next   = req.divisor;
            rem_next   = '0;
        end
        else if (run_reg)
        begin
            shift_next = {shift_reg[KW-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_next = SW'(trial - {1'b0, div_reg});
            else
                rem_next = trial[SW-1:0];
            step_next = step_reg + TW'(1);
            if (step_reg == TW'(KW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: verif/tb_set_assoc_lru_cache.sv
// Self-checking testbench for the set-associative LRU key/value cache.
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache;

    localparam int SETS       = 64;
    localparam int WAYS       = 4;
    localparam int QUIET_MAX  = 2000;
    localparam int POOL_SIZE  = 20;
    localparam int PHASE_OPS  = 135;
    localparam int KEY_W      = salc_pkg::KEY_W;
    localparam int DATA_W     = salc_pkg::DATA_W;
    localparam int CNT_W      = salc_pkg::CNT_W;
    localparam int SIU_W      = salc_pkg::SIU_W;

    typedef struct {
        salc_pkg::salc_item_t beat;
        int unsigned          gap;
    } queued_op_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    salc_pkg::salc_item_t   item_beat = '0;
    logic                   done;
    salc_pkg::salc_result_t res_beat;
    logic                   cfg_we = 1'b0;
    logic [SIU_W-1:0]       cfg_wdata = '0;

    // Cache shadow state
    logic                line_valid [SETS][WAYS];
    logic [KEY_W-1:0]    line_key   [SETS][WAYS];
    logic [DATA_W-1:0]   line_value [SETS][WAYS];
    int unsigned         lru_list   [SETS][WAYS];
    logic [CNT_W-1:0]    hits_seen;
    logic [CNT_W-1:0]    misses_seen;
    logic [SIU_W-1:0]    model_sets;

    queued_op_t             op_queue[$];
    salc_pkg::salc_result_t expected_results[$];
    queued_op_t             staged_op;
    bit                     staged_valid = 1'b0;
    int unsigned            hold_cycles = 0;
    bit                     burst_on = 1'b0;
    logic                   nxt_start;
    salc_pkg::salc_item_t   nxt_beat;
    int unsigned            mismatch_count = 0;
    int unsigned            quiet_cycles = 0;
    logic [KEY_W-1:0]       key_pool [POOL_SIZE];

    set_assoc_lru_cache #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item_beat),
        .done      (done),
        .result    (res_beat),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Clamp the programmed set count to the range the cache supports
    function automatic int unsigned eff_sets(logic [SIU_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > SETS)
            return SETS;
        return v;
    endfunction

    // Move a way to the head of its set's recency list
    function automatic void promote_way(int unsigned s, int unsigned way);
        int unsigned pos;
        pos = WAYS - 1;
        for (int i = WAYS - 1; i >= 0; i--)
            if (lru_list[s][i] == way)
                pos = i;
        for (int i = pos; i > 0; i--)
            lru_list[s][i] = lru_list[s][i-1];
        lru_list[s][0] = way;
    endfunction

    // Apply one beat to the shadow cache and return the result it yields
    function automatic salc_pkg::salc_result_t cache_access(salc_pkg::salc_item_t op);
        salc_pkg::salc_result_t r;
        int unsigned  set_idx;
        int unsigned  victim;
        bit           found;
        r = '0;
        found = 1'b0;
        set_idx = op.key % eff_sets(model_sets);
        if (op.func == salc_pkg::FUNC_GET)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (!found && line_valid[set_idx][w] && line_key[set_idx][w] == op.key)
                begin
                    found = 1'b1;
                    promote_way(set_idx, w);
                    r.hit = 1'b1;
                    r.read_data = line_value[set_idx][w];
                end
            end
            if (found)
                hits_seen = hits_seen + 1;
            else
                misses_seen = misses_seen + 1;
        end
        else
        begin
            victim = lru_list[set_idx][WAYS-1];
            for (int w = 0; w < WAYS; w++)
            begin
                if (!found && !line_valid[set_idx][w])
                begin
                    victim = w;
                    found = 1'b1;
                end
            end
            line_key[set_idx][victim]   = op.key;
            line_value[set_idx][victim] = op.write_data;
            line_valid[set_idx][victim] = 1'b1;
            promote_way(set_idx, victim);
        end
        r.hit_total  = hits_seen;
        r.miss_total = misses_seen;
        return r;
    endfunction

    // Driver: present queued beats, honoring each beat's idle gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            item_beat <= '0;
        end
        else
        begin
            nxt_start = start;
            nxt_beat  = item_beat;
            if (start && !busy)
            begin
                expected_results.push_back(cache_access(item_beat));
                nxt_start = 1'b0;
            end
            if (!nxt_start)
            begin
                if (!staged_valid && op_queue.size() != 0)
                begin
                    staged_op    = op_queue.pop_front();
                    staged_valid = 1'b1;
                    hold_cycles  = staged_op.gap;
                end
                if (staged_valid)
                begin
                    if (hold_cycles == 0)
                    begin
                        nxt_start    = 1'b1;
                        nxt_beat     = staged_op.beat;
                        staged_valid = 1'b0;
                    end
                    else
                        hold_cycles--;
                end
            end
            start     <= nxt_start;
            item_beat <= nxt_beat;
        end
    end

    // Monitor: check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with no prediction pending");
                mismatch_count++;
            end
            else
            begin
                salc_pkg::salc_result_t exp_r;
                exp_r = expected_results.pop_front();
                if (res_beat.hit !== exp_r.hit)
                begin
                    $error("hit: expected %0d, got %0d", exp_r.hit, res_beat.hit);
                    mismatch_count++;
                end
                if (res_beat.read_data !== exp_r.read_data)
                begin
                    $error("read_data: expected %0d, got %0d",
                           exp_r.read_data, res_beat.read_data);
                    mismatch_count++;
                end
                if (res_beat.hit_total !== exp_r.hit_total)
                begin
                    $error("hit_total: expected %0d, got %0d",
                           exp_r.hit_total, res_beat.hit_total);
                    mismatch_count++;
                end
                if (res_beat.miss_total !== exp_r.miss_total)
                begin
                    $error("miss_total: expected %0d, got %0d",
                           exp_r.miss_total, res_beat.miss_total);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: stop when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_MAX)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Queue one beat; the gap comes from the current idling mode
    task automatic push_op(logic func, logic [KEY_W-1:0] key, logic [DATA_W-1:0] data);
        queued_op_t op;
        if ($urandom_range(0, 15) == 0)
            burst_on = !burst_on;
        op.beat.func       = func;
        op.beat.key        = key;
        op.beat.write_data = data;
        op.gap             = burst_on ? 0 : $urandom_range(0, 19);
        op_queue.push_back(op);
    endtask

    // Wait until every queued beat is taken and every result is back
    task automatic drain();
        while (op_queue.size() != 0 || staged_valid || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Program sets_in_use while the cache is idle
    task automatic write_sets(logic [SIU_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_sets = v;
    endtask

    // Random traffic: mostly keys crowded into a few sets, plus wide-open noise
    task automatic fill_phase(int unsigned count);
        int unsigned   n_sets;
        int unsigned   crowd;
        longint        k;
        logic [KEY_W-1:0] key;
        int unsigned   n;
        n_sets = eff_sets(model_sets);
        crowd  = (n_sets < 3) ? n_sets : 3;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            k = longint'($urandom_range(0, 32'h7FFF_FFFF / n_sets)) * n_sets
                + $urandom_range(0, crowd - 1);
            if (k > 64'h7FFF_FFFF)
                k = k - n_sets;
            key_pool[i] = k[KEY_W-1:0];
        end
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                if ($urandom_range(0, 99) < 55)
                begin
                    push_op(salc_pkg::FUNC_GET, key, $urandom);
                    n++;
                end
                else
                begin
                    push_op(salc_pkg::FUNC_PUT, key, $urandom);
                    n++;
                    if ($urandom_range(0, 99) < 40)
                    begin
                        push_op(salc_pkg::FUNC_GET, key, $urandom);
                        n++;
                    end
                end
            end
            else
            begin
                push_op($urandom_range(0, 1) ? salc_pkg::FUNC_PUT : salc_pkg::FUNC_GET,
                        KEY_W'($urandom), $urandom);
                n++;
            end
        end
    endtask

    initial
    begin
        logic [SIU_W-1:0] phase_sets [10];
        phase_sets = '{7'd1, 7'd0, 7'd127, 7'd7, 7'd2, 7'd64, 7'd40, 7'd3, 7'd13, 7'd64};

        // Shadow reset state
        for (int s = 0; s < SETS; s++)
            for (int w = 0; w < WAYS; w++)
            begin
                line_valid[s][w] = 1'b0;
                line_key[s][w]   = '0;
                line_value[s][w] = '0;
                lru_list[s][w]   = w;
            end
        hits_seen   = '0;
        misses_seen = '0;
        model_sets  = salc_pkg::SIU_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Hold off until the clearing sweep finishes
        @(posedge clk);
        while (busy)
            @(posedge clk);
        write_sets(7'd64);

        // Directed: empty lookup, extreme keys and data
        push_op(salc_pkg::FUNC_GET, 31'd0, 32'h1234_5678);
        push_op(salc_pkg::FUNC_PUT, 31'd0, 32'h7FFF_FFFF);
        push_op(salc_pkg::FUNC_GET, 31'd0, 32'hFFFF_FFFF);
        push_op(salc_pkg::FUNC_PUT, 31'h7FFF_FFFF, 32'h8000_0000);
        push_op(salc_pkg::FUNC_GET, 31'h7FFF_FFFF, 32'h0);
        // Fill set 1, refresh one way, then force an eviction of the oldest
        push_op(salc_pkg::FUNC_PUT, 31'd1, 32'd11);
        push_op(salc_pkg::FUNC_PUT, 31'd65, 32'd22);
        push_op(salc_pkg::FUNC_PUT, 31'd129, 32'd33);
        push_op(salc_pkg::FUNC_PUT, 31'd193, 32'd44);
        push_op(salc_pkg::FUNC_GET, 31'd1, 32'd0);
        push_op(salc_pkg::FUNC_PUT, 31'd257, 32'd55);
        push_op(salc_pkg::FUNC_GET, 31'd65, 32'd0);
        push_op(salc_pkg::FUNC_GET, 31'd1, 32'd0);
        push_op(salc_pkg::FUNC_GET, 31'd257, 32'd0);
        // Put key 129 again: the least recent way, which holds the old 129, is replaced
        push_op(salc_pkg::FUNC_PUT, 31'd129, 32'hFFFF_FFFF);
        push_op(salc_pkg::FUNC_GET, 31'd129, 32'd0);
        push_op(salc_pkg::FUNC_PUT, 31'h2AAA_AAAA, 32'h5555_5555);
        push_op(salc_pkg::FUNC_GET, 31'h2AAA_AAAA, 32'hAAAA_AAAA);
        push_op(salc_pkg::FUNC_GET, 31'h5555_5555, 32'd0);
        drain();

        // Random phases, one per entry of the set count list
        foreach (phase_sets[p])
        begin
            write_sets(phase_sets[p]);
            fill_phase(PHASE_OPS);
            drain();
        end

        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
